// ===== design/i2cts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
// Used by every module of the block; depends on nothing.
package i2cts_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [2:0] {
    OP_REQUEST  = 3'd0,
    OP_START    = 3'd1,
    OP_ADDRESS  = 3'd2,
    OP_RXFULL   = 3'd3,
    OP_BYTEDONE = 3'd4,
    OP_TXEMPTY  = 3'd5
  } op_e;

  // One event or request as seen by the sequencer core.
  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] dev_addr;
    logic [1:0] write_count;
    logic [7:0] write_first;
    logic [7:0] write_second;
    logic [1:0] read_count;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
  } item_t;

  // One result of a step.
  typedef struct packed {
    logic       accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       stop_req;
    logic       start_req;
    logic       ack_level;
    logic       pos_level;
    logic       done_res;
    logic [7:0] read_first;
    logic [7:0] read_second;
    logic       busy_res;
  } res_t;

  // Handshake between the input and result registers.
  typedef struct packed {
    logic item_valid;
    logic res_free;
  } flow_t;

endpackage

// ===== design/i2cts_in_stage.sv =====
// Input register of the sequencer: holds one request until the core takes it.
// Depends on i2cts_pkg.
module i2cts_in_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [i2cts_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic [i2cts_pkg::InUserW-1:0]    s_axis_tuser_i,
  input  logic                             res_free_i,
  output i2cts_pkg::item_t                 item_o,
  output logic                             item_valid_o
);
  import i2cts_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take, advance;

  assign advance         = valid_q && res_free_i;
  assign s_axis_tready_o = !valid_q || advance;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_d              = item_q;
    valid_d             = valid_q;
    if (advance) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d              = 1'b1;
      item_d.opcode        = s_axis_tuser_i;
      item_d.dev_addr      = s_axis_tdata_i[6:0];
      item_d.write_count   = s_axis_tdata_i[8:7];
      item_d.write_first   = s_axis_tdata_i[16:9];
      item_d.write_second  = s_axis_tdata_i[24:17];
      item_d.read_count    = s_axis_tdata_i[26:25];
      item_d.rx_first      = s_axis_tdata_i[34:27];
      item_d.rx_second     = s_axis_tdata_i[42:35];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

// ===== design/i2cts_core.sv =====
// Transaction state and the per-event step logic of the sequencer.
// Depends on i2cts_pkg.
module i2cts_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  i2cts_pkg::item_t item_i,
  output i2cts_pkg::res_t  res_o
);
  import i2cts_pkg::*;

  logic       slot_full_q, slot_full_d;
  logic       active_q, active_d;
  logic       wpd_q, wpd_d;
  logic [1:0] bytes_left_q, bytes_left_d;
  logic [6:0] target_q, target_d;
  logic [7:0] out0_q, out0_d;
  logic [7:0] out1_q, out1_d;
  logic [1:0] reads_q, reads_d;
  logic       ack_q, ack_d;
  logic       pos_q, pos_d;
  logic       skip_stop;
  res_t       r;

  always_comb begin
    slot_full_d  = slot_full_q;
    active_d     = active_q;
    wpd_d        = wpd_q;
    bytes_left_d = bytes_left_q;
    target_d     = target_q;
    out0_d       = out0_q;
    out1_d       = out1_q;
    reads_d      = reads_q;
    ack_d        = ack_q;
    pos_d        = pos_q;
    skip_stop    = 1'b0;
    r            = '0;

    unique case (item_i.opcode)
      OP_REQUEST: begin
        if (!slot_full_q) begin
          slot_full_d = 1'b1;
          target_d    = item_i.dev_addr;
          // Clamp counts into range: write 1..2, read 0..2.
          bytes_left_d = (item_i.write_count == 2'd0) ? 2'd1 :
                         (item_i.write_count == 2'd3) ? 2'd2 : item_i.write_count;
          reads_d      = (item_i.read_count == 2'd3) ? 2'd2 : item_i.read_count;
          out0_d       = item_i.write_first;
          out1_d       = item_i.write_second;
          wpd_d        = 1'b0;
          r.accepted   = 1'b1;
        end
      end
      OP_START: begin
        if (active_q || slot_full_q) begin
          active_d   = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_byte  = {target_q, wpd_q};
        end
      end
      OP_ADDRESS: begin
        if (active_q) begin
          if (wpd_q) begin
            if (reads_q == 2'd1) begin
              ack_d = 1'b0;
            end else if (reads_q == 2'd2) begin
              pos_d     = 1'b1;
              ack_d     = 1'b0;
              skip_stop = 1'b1;
            end
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = out0_q;
            if (bytes_left_q != 2'd0) begin
              bytes_left_d = bytes_left_q - 2'd1;
            end
          end
          // Stop is requested here when nothing is left to write, except at the address of a two-byte read.
          r.stop_req = !skip_stop && (bytes_left_d == 2'd0);
        end
      end
      OP_RXFULL: begin
        if (active_q && wpd_q) begin
          if (reads_q == 2'd1) begin
            r.read_first = item_i.rx_first;
            ack_d        = 1'b1;
            active_d     = 1'b0;
            slot_full_d  = 1'b0;
            r.done_res   = 1'b1;
          end else if (reads_q == 2'd2) begin
            r.stop_req    = 1'b1;
            r.read_first  = item_i.rx_first;
            r.read_second = item_i.rx_second;
            pos_d         = 1'b0;
            ack_d         = 1'b1;
            active_d      = 1'b0;
            slot_full_d   = 1'b0;
            r.done_res    = 1'b1;
          end
        end
      end
      OP_BYTEDONE: begin
        if (active_q && !wpd_q) begin
          if (bytes_left_q != 2'd0) begin
            r.tx_valid   = 1'b1;
            r.tx_byte    = out1_q;
            bytes_left_d = bytes_left_q - 2'd1;
          end else begin
            r.stop_req = 1'b1;
            wpd_d      = 1'b1;
            if (reads_q != 2'd0) begin
              r.start_req = 1'b1;
            end else begin
              active_d    = 1'b0;
              slot_full_d = 1'b0;
              r.done_res  = 1'b1;
            end
          end
        end
      end
      default: begin
        // Transmit empty and unused codes leave everything as is.
      end
    endcase

    r.ack_level = ack_d;
    r.pos_level = pos_d;
    r.busy_res  = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_full_q  <= 1'b0;
      active_q     <= 1'b0;
      wpd_q        <= 1'b0;
      bytes_left_q <= 2'd0;
      target_q     <= 7'd0;
      reads_q      <= 2'd0;
      ack_q        <= 1'b1;
      pos_q        <= 1'b0;
    end else if (step_i) begin
      slot_full_q  <= slot_full_d;
      active_q     <= active_d;
      wpd_q        <= wpd_d;
      bytes_left_q <= bytes_left_d;
      target_q     <= target_d;
      reads_q      <= reads_d;
      ack_q        <= ack_d;
      pos_q        <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      out0_q <= out0_d;
      out1_q <= out1_d;
    end
  end

  assign res_o = r;

endmodule

// ===== design/i2cts_out_stage.sv =====
// Result register of the sequencer, driving the master-side stream.
// Depends on i2cts_pkg.
module i2cts_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  i2cts_pkg::flow_t                flow_i,
  input  i2cts_pkg::res_t                 res_i,
  output logic                            res_free_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [i2cts_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import i2cts_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  assign res_free_o = !valid_q || m_axis_tready_i;
  assign load       = flow_i.item_valid && flow_i.res_free;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && m_axis_tready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {res_q.busy_res, res_q.read_second, res_q.read_first,
                            res_q.done_res, res_q.pos_level, res_q.ack_level,
                            res_q.start_req, res_q.stop_req, res_q.tx_byte,
                            res_q.tx_valid, res_q.accepted};

endmodule

// ===== design/i2c_master_transaction_sequencer.sv =====
// Channel   Dir  Ports                     Contents
// s_axis    in   tvalid/tready/tdata/tuser request or bus event, opcode in tuser
// m_axis    out  tvalid/tready/tdata       one result per accepted item
//
// One item per cycle sustained while m_axis takes results. An item is held in the
// input register, where the core works out its result and state update, then sits
// in the result register until taken.
// Reset leaves the slot empty, no transaction active, ack level 1, POS level 0.
// A stall on m_axis holds the result register, then the input register fills.
// Top level; depends on i2cts_pkg, i2cts_in_stage, i2cts_core, i2cts_out_stage.
module i2c_master_transaction_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [6:0] dev_addr, [8:7] write_count, [16:9] write_first, [24:17] write_second,
  // [26:25] read_count, [34:27] rx_first, [42:35] rx_second, [47:43] zero
  input  logic [i2cts_pkg::InDataW-1:0]    s_axis_tdata,
  // [2:0] opcode
  input  logic [i2cts_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] accepted, [1] tx_valid, [9:2] tx_byte, [10] stop_req, [11] start_req,
  // [12] ack_level, [13] pos_level, [14] done_res, [22:15] read_first,
  // [30:23] read_second, [31] busy_res
  output logic [i2cts_pkg::OutDataW-1:0]   m_axis_tdata
);
  import i2cts_pkg::*;

  item_t item;
  res_t  res;
  flow_t flow;
  logic  item_valid;
  logic  res_free;

  assign flow.item_valid = item_valid;
  assign flow.res_free   = res_free;

  i2cts_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .res_free_i      (res_free),
    .item_o          (item),
    .item_valid_o    (item_valid)
  );

  i2cts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (item_valid && res_free),
    .item_i (item),
    .res_o  (res)
  );

  i2cts_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flow_i          (flow),
    .res_i           (res),
    .res_free_o      (res_free),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule
